@@ sv/case_insensitive_word_marker_defines.svh @@
// assertion macros shared by the word marker modules
// no dependencies; include by bare file name
`ifndef CASE_INSENSITIVE_WORD_MARKER_DEFINES_SVH
`define CASE_INSENSITIVE_WORD_MARKER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CISM_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CISM_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cism_pkg.sv @@
// shared types, constants and character helpers for the word marker
// no dependencies
package cism_pkg;

	localparam int CHAR_W    = 8;
	localparam int TOTAL_W   = 32;
	localparam int CFG_W     = 64;
	localparam int REG_CHARS = 16;
	localparam int LENREG_W  = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHARS_LOW  = 2'd0,
		CFG_CHARS_HIGH = 2'd1,
		CFG_WORD_LEN   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  out_char;
		logic [TOTAL_W-1:0] occurrence_total;
		logic               stream_done;
	} out_word_t;

	function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

@@ sv/case_insensitive_word_marker.sv @@
// case-insensitive word marker: counts word hits in a byte stream and upper-cases hit bytes
// depends on cism_pkg, cism_match, cism_skid, case_insensitive_word_marker_defines.svh
//
// usage
//  - input channel in_valid/in_stall/in_word carries one text byte per word, with
//    end_of_stream set on the final byte of a stream
//  - output channel out_valid/out_stall/out_word carries delayed bytes, the running
//    hit total and stream_done on the last byte of a flushed stream
//  - configuration: cfg_we writes cfg_data into the register chosen by cfg_index
//    (word characters low, word characters high, word length); write only when idle
//  - bytes are delayed by word length minus one words; every byte inside a hit leaves
//    in upper case, overlapping hits count separately, the total saturates
//  - path: a byte is held in the input stage register, and the word its window step
//    emits is registered in the output buffer before it appears on out_valid
//  - throughput: one word per cycle in steady state while the output buffer has room;
//    the single-pass window step emits at most one result per cycle, so a stream end
//    holds the input until the bytes left in the window after the last byte (at most the
//    word length minus one) are flushed; a shortened length holds it until surplus drains
//  - a stalled output fills a two-entry buffer; once full the window step waits and a
//    held byte keeps the input stalled
//  - reset clears window, total and configuration (word length 1); after stream_done
//    the total restarts from zero
`include "case_insensitive_word_marker_defines.svh"

module case_insensitive_word_marker #(
	parameter int MAX_WORD = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  cism_pkg::in_word_t                     in_word,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output cism_pkg::out_word_t                    out_word,
	input  logic                                   cfg_we,
	input  logic [cism_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cism_pkg::CFG_W-1:0]             cfg_data
);

	// window depth: the word can never exceed the character registers
	localparam int WIN   = (MAX_WORD < cism_pkg::REG_CHARS) ? MAX_WORD : cism_pkg::REG_CHARS;
	localparam int LEN_W = $clog2(WIN + 1);

	// configuration registers
	logic [cism_pkg::CFG_W-1:0]    chars_low_q;
	logic [cism_pkg::CFG_W-1:0]    chars_high_q;
	logic [cism_pkg::LENREG_W-1:0] word_len_q;

	// held input word (the stage register in front of the window step)
	logic                          pend_valid_q;
	logic [cism_pkg::CHAR_W-1:0]   pend_char_q;
	logic                          pend_last_q;
	logic                          app_q;   // byte already appended, stream flush running

	// delay window
	logic [WIN-1:0][cism_pkg::CHAR_W-1:0] win_q;
	logic [WIN-1:0]                       mark_q;
	logic [LEN_W-1:0]                     fill_q;
	logic [cism_pkg::TOTAL_W-1:0]         total_q;

	// next-state and step results
	logic [WIN-1:0][cism_pkg::CHAR_W-1:0] win_n;
	logic [WIN-1:0]                       mark_n;
	logic [LEN_W-1:0]                     fill_n;
	logic [cism_pkg::TOTAL_W-1:0]         total_n;
	logic                                 app_n;
	logic                                 emit;
	logic                                 done;
	logic                                 sdone;
	cism_pkg::out_word_t                  emit_word;

	logic [WIN-1:0][cism_pkg::CHAR_W-1:0] cmp_win;
	logic [cism_pkg::LENREG_W-1:0]        len5;
	logic [LEN_W-1:0]                     len;
	logic                                 hit;
	logic                                 skid_full;
	logic                                 in_take;

	// effective length: zero acts as one, clamp to window depth
	always_comb begin
		if (word_len_q == '0) begin
			len5 = cism_pkg::LENREG_W'(1);
		end else if (word_len_q > cism_pkg::LENREG_W'(WIN)) begin
			len5 = cism_pkg::LENREG_W'(WIN);
		end else begin
			len5 = word_len_q;
		end
	end
	assign len = LEN_W'(len5);

	// window as it looks with the held byte appended at the fill point
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			cmp_win[i] = (LEN_W'(i) == fill_q) ? pend_char_q : win_q[i];
		end
	end

	cism_match #(
		.WIN   (WIN),
		.LEN_W (LEN_W)
	) u_match (
		.window     (cmp_win),
		.word_chars ({chars_high_q, chars_low_q}),
		.len        (len),
		.hit        (hit)
	);

	// one window step per cycle while a byte is held and the output buffer has room, at most one result per step
	always_comb begin
		win_n     = win_q;
		mark_n    = mark_q;
		fill_n    = fill_q;
		total_n   = total_q;
		app_n     = app_q;
		emit      = 1'b0;
		done      = 1'b0;
		sdone     = 1'b0;
		emit_word = '0;
		if (pend_valid_q && !skid_full) begin
			if (!app_q && fill_q >= len) begin
				// length shrank: drain surplus bytes unchecked, old total
				emit = 1'b1;
			end else if (!app_q) begin
				win_n = cmp_win;
				for (int i = 0; i < WIN; i++) begin
					if (LEN_W'(i) == fill_q) begin
						mark_n[i] = 1'b0;
					end
				end
				fill_n = fill_q + 1'b1;
				app_n  = 1'b1;
				if (fill_n == len) begin
					if (hit) begin
						total_n = (total_q == '1) ? total_q : total_q + 1'b1;
						for (int i = 0; i < WIN; i++) begin
							if (LEN_W'(i) < len) begin
								mark_n[i] = 1'b1;
							end
						end
					end
					emit = 1'b1;
				end
			end else begin
				// stream end flush
				emit = 1'b1;
			end

			if (emit) begin
				emit_word.out_char         = mark_n[0] ? cism_pkg::fold_upper(win_n[0])
				                                       : win_n[0];
				emit_word.occurrence_total = total_n;
				for (int i = 0; i < WIN - 1; i++) begin
					win_n[i]  = win_n[i+1];
					mark_n[i] = mark_n[i+1];
				end
				mark_n[WIN-1] = 1'b0;
				fill_n        = fill_n - 1'b1;
			end

			if (app_n) begin
				sdone = pend_last_q && emit && (fill_n == '0);
				done  = !pend_last_q || sdone;
			end
			emit_word.stream_done = sdone;

			if (sdone) begin
				total_n = '0;
			end
			if (done) begin
				app_n = 1'b0;
			end
		end
	end

	assign in_stall = pend_valid_q && !done;
	assign in_take  = in_valid && !in_stall;

	cism_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_word (emit_word),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// payload registers
	always_ff @(posedge clk) begin
		win_q <= win_n;
		if (in_take) begin
			pend_char_q <= in_word.in_char;
			pend_last_q <= in_word.end_of_stream;
		end
	end

	// control state, totals and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			app_q        <= 1'b0;
			mark_q       <= '0;
			fill_q       <= '0;
			total_q      <= '0;
			chars_low_q  <= '0;
			chars_high_q <= '0;
			word_len_q   <= cism_pkg::LENREG_W'(1);
		end else begin
			mark_q  <= mark_n;
			fill_q  <= fill_n;
			total_q <= total_n;
			if (in_take) begin
				pend_valid_q <= 1'b1;
				app_q        <= 1'b0;
			end else begin
				app_q <= app_n;
				if (done) begin
					pend_valid_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					cism_pkg::CFG_CHARS_LOW:  chars_low_q  <= cfg_data;
					cism_pkg::CFG_CHARS_HIGH: chars_high_q <= cfg_data;
					cism_pkg::CFG_WORD_LEN:   word_len_q   <= cfg_data[cism_pkg::LENREG_W-1:0];
					default: ;
				endcase
			end
		end
	end

	`CISM_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q < LEN_W'(WIN), "window fill overrun")
	`CISM_ASSERT_NXT(a_done_clears, clk, arst_n, emit && sdone, ~|{total_q, fill_q}, "no clear at end")
	`CISM_ASSERT_IMP(a_flush_at_end, clk, arst_n, pend_valid_q && app_q, pend_last_q, "stray flush")

endmodule

@@ sv/cism_match.sv @@
// parallel case-folded compare of the window against the word, up to the word length
// depends on cism_pkg
module cism_match #(
	parameter int WIN   = 16,
	parameter int LEN_W = 5
) (
	input  logic [WIN-1:0][cism_pkg::CHAR_W-1:0]                   window,
	input  logic [cism_pkg::REG_CHARS-1:0][cism_pkg::CHAR_W-1:0]   word_chars,
	input  logic [LEN_W-1:0]                                       len,
	output logic                                                   hit
);

	logic [WIN-1:0] eq;

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			// positions past the word length always agree
			eq[i] = (LEN_W'(i) >= len) ||
				(cism_pkg::fold_lower(window[i]) == cism_pkg::fold_lower(word_chars[i]));
		end
	end

	assign hit = &eq;

endmodule

@@ sv/cism_skid.sv @@
// two-entry output buffer that decouples result stall from the datapath
// depends on cism_pkg and case_insensitive_word_marker_defines.svh
`include "case_insensitive_word_marker_defines.svh"

module cism_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cism_pkg::out_word_t  push_word,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cism_pkg::out_word_t  out_word
);

	cism_pkg::out_word_t buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_word  = buf_q[rd_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`CISM_ASSERT_IMP(a_no_push_when_full, clk, arst_n, push, !full, "push into full buffer")
	`CISM_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "buffer count overrun")

endmodule
